// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, masked while reset is high.
`define MEC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mouse event conditioner assertion failed");

// Concurrent assertion that also holds across reset.
`define MEC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("mouse event conditioner assertion failed");

`endif

// ===== rtl/mec_pkg.sv =====
// Shared types, constants and helper functions of the mouse event conditioner.
`timescale 1ns / 1ps
package mec_pkg;

   localparam int DELTA_W     = 16;
   localparam int MASK_W      = 7;
   localparam int BTN_W       = 3;
   localparam int CMD_W       = 2;
   localparam int THR_W       = 15;
   localparam int TICKS_W     = 16;
   localparam int TIME_W      = 17;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [THR_W-1:0]   THR_RESET   = 15'd64;
   localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd1000;
   localparam logic [TIME_W-1:0]  TIME_MAX    = 17'h1FFFF;

   typedef enum logic [CMD_W-1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_TICK   = 2'd1,
      CMD_ACK    = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SPEED_THRESHOLD = 1'b0,
      CSR_WINDOW_TICKS    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [THR_W-1:0]   speed_threshold;
      logic [TICKS_W-1:0] window_ticks;
   } cfg_type;

   typedef struct packed {
      logic [CMD_W-1:0]          command;
      logic signed [DELTA_W-1:0] delta_x;
      logic signed [DELTA_W-1:0] delta_y;
      logic [BTN_W-1:0]          button_state;
   } req_type;

   typedef struct packed {
      logic [MASK_W-1:0]         event_mask;
      logic signed [DELTA_W-1:0] report_x;
      logic signed [DELTA_W-1:0] report_y;
   } rsp_type;

   // Magnitude of a 16-bit two's complement value; the most negative one wraps to itself.
   function automatic logic [DELTA_W-1:0] mag16(input logic [DELTA_W-1:0] v);
      return v[DELTA_W-1] ? (~v + {{(DELTA_W-1){1'b0}}, 1'b1}) : v;
   endfunction

endpackage

// ===== rtl/mec_if.sv =====
// Valid/ready channel interfaces for mouse transactions and reports.
`timescale 1ns / 1ps
interface mec_req_if;
   import mec_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          command;
   logic signed [DELTA_W-1:0] delta_x;
   logic signed [DELTA_W-1:0] delta_y;
   logic [BTN_W-1:0]          button_state;

   modport source(output valid, command, delta_x, delta_y, button_state, input ready);
   modport sink(input valid, command, delta_x, delta_y, button_state, output ready);
endinterface

interface mec_rsp_if;
   import mec_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [MASK_W-1:0]         event_mask;
   logic signed [DELTA_W-1:0] report_x;
   logic signed [DELTA_W-1:0] report_y;

   modport source(output valid, event_mask, report_x, report_y, input ready);
   modport sink(input valid, event_mask, report_x, report_y, output ready);
endinterface

// ===== rtl/mec_csr.sv =====
// Configuration registers: speed threshold and window length.
`timescale 1ns / 1ps
module mec_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [mec_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mec_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   output mec_pkg::cfg_type               cfg
);
   import mec_pkg::*;

   cfg_type cfg_ff;

   // Write the addressed register; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_threshold <= THR_RESET;
         cfg_ff.window_ticks    <= TICKS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_SPEED_THRESHOLD: begin
               cfg_ff.speed_threshold <= csr_wr_data[THR_W-1:0];
            end
            CSR_WINDOW_TICKS: begin
               cfg_ff.window_ticks <= csr_wr_data[TICKS_W-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/mec_core.sv =====
// Motion state, acceleration window and report datapath.
`timescale 1ns / 1ps
module mec_core (
   input  logic             clock,
   input  logic             reset,
   input  mec_pkg::cfg_type cfg,
   input  logic             item_valid,
   input  logic             item_fire,
   input  mec_pkg::req_type item,
   output logic             item_has_rsp,
   output mec_pkg::rsp_type rsp_data
);
   import mec_pkg::*;

   logic [DELTA_W-1:0] pending_x_ff, pending_y_ff;
   logic [DELTA_W-1:0] win_sum_x_ff, win_sum_y_ff, win_total_ff;
   logic [TIME_W-1:0]  win_time_ff;
   logic [BTN_W-1:0]   prev_btn_ff;
   logic               irq_pending_ff;

   cmd_type            cmd;
   logic [DELTA_W-1:0] acc_x, acc_y;
   logic               moving;
   logic               expired;
   logic [DELTA_W-1:0] base_x, base_y, base_t;
   logic [TIME_W-1:0]  time_eff;
   logic [DELTA_W-1:0] sum_x_new, sum_y_new, total_new;
   logic               boost;
   logic [MASK_W-1:0]  mask;

   // Accumulate doubled motion, run the window check and build the report
   always_comb begin
      cmd       = cmd_type'(item.command);
      acc_x     = pending_x_ff + {item.delta_x[DELTA_W-2:0], 1'b0};
      acc_y     = pending_y_ff + {item.delta_y[DELTA_W-2:0], 1'b0};
      moving    = (acc_x != '0) || (acc_y != '0);
      expired   = win_time_ff > {1'b0, cfg.window_ticks};
      base_x    = expired ? '0 : win_sum_x_ff;
      base_y    = expired ? '0 : win_sum_y_ff;
      base_t    = expired ? '0 : win_total_ff;
      time_eff  = expired ? '0 : win_time_ff;
      sum_x_new = base_x + acc_x;
      sum_y_new = base_y + acc_y;
      total_new = base_t + mag16(acc_x) + mag16(acc_y);
      boost     = (time_eff < {1'b0, cfg.window_ticks}) && !total_new[DELTA_W-1] &&
                  (total_new[DELTA_W-2:0] >= cfg.speed_threshold);
      mask      = '0;
      mask[0]   = moving;
      for (int i = 0; i < BTN_W; i++) begin
         mask[1 + 2*i] = item.button_state[i] & ~prev_btn_ff[i];
         mask[2 + 2*i] = ~item.button_state[i] & prev_btn_ff[i];
      end
      rsp_data.event_mask = mask;
      rsp_data.report_x   = (moving && boost) ? (acc_x + sum_x_new) : acc_x;
      rsp_data.report_y   = (moving && boost) ? (acc_y + sum_y_new) : acc_y;
      item_has_rsp        = item_valid && (cmd == CMD_SAMPLE) && !irq_pending_ff;
   end

   // Advance the state on each transaction that leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_x_ff   <= '0;
         pending_y_ff   <= '0;
         win_sum_x_ff   <= '0;
         win_sum_y_ff   <= '0;
         win_total_ff   <= '0;
         win_time_ff    <= '0;
         prev_btn_ff    <= '0;
         irq_pending_ff <= 1'b0;
      end else if (item_fire) begin
         case (cmd)
            CMD_TICK: begin
               if (win_time_ff != TIME_MAX) begin
                  win_time_ff <= win_time_ff + {{(TIME_W-1){1'b0}}, 1'b1};
               end
            end
            CMD_ACK: begin
               irq_pending_ff <= 1'b0;
            end
            CMD_SAMPLE: begin
               if (irq_pending_ff) begin
                  pending_x_ff <= acc_x;
                  pending_y_ff <= acc_y;
               end else begin
                  pending_x_ff   <= '0;
                  pending_y_ff   <= '0;
                  prev_btn_ff    <= item.button_state;
                  irq_pending_ff <= (mask != '0);
                  if (moving) begin
                     if (boost) begin
                        win_sum_x_ff <= '0;
                        win_sum_y_ff <= '0;
                        win_total_ff <= '0;
                        win_time_ff  <= '0;
                     end else begin
                        win_sum_x_ff <= sum_x_new;
                        win_sum_y_ff <= sum_y_new;
                        win_total_ff <= total_new;
                        win_time_ff  <= time_eff;
                     end
                  end
               end
            end
            default: begin
               irq_pending_ff <= irq_pending_ff;
            end
         endcase
      end
   end

endmodule

// ===== rtl/mec_out_reg.sv =====
// Result register between the datapath and the report channel.
`timescale 1ns / 1ps
module mec_out_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  mec_pkg::rsp_type load_data,
   output logic             out_free,
   mec_rsp_if.source        rsp_chan
);
   import mec_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;

   assign out_free = !valid_ff || rsp_chan.ready;

   // Hold the report until taken; a new one may replace it in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_free) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (load && out_free) begin
         data_ff <= load_data;
      end
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.event_mask = data_ff.event_mask;
   assign rsp_chan.report_x   = data_ff.report_x;
   assign rsp_chan.report_y   = data_ff.report_y;

endmodule

// ===== rtl/mouse_event_conditioner_unit.sv =====
// A sample's report passes the input register, then the result register, and is held
// in the result register until the report channel takes it.
// Throughput: one transaction per cycle; the input register only waits when a report
// is due and the result register is still held by a stalled report channel.
// Reset: synchronous, active high; clears motion, window, buttons, interrupt flag and
// loads speed_threshold 64 and window_ticks 1000. No clearing pass.
`timescale 1ns / 1ps
module mouse_event_conditioner_unit (
   input  logic                            clock,
   input  logic                            reset,
   mec_req_if.sink                         req_chan,
   mec_rsp_if.source                       rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [mec_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mec_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import mec_pkg::*;

   cfg_type cfg;
   logic    in_valid_ff;
   req_type in_data_ff;
   logic    item_has_rsp;
   logic    item_fire;
   logic    out_free;
   rsp_type rsp_data;

   mec_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data),
      .cfg        (cfg)
   );

   // Release the held transaction unless its report has nowhere to go
   assign item_fire      = in_valid_ff && (!item_has_rsp || out_free);
   assign req_chan.ready = !in_valid_ff || item_fire;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_data_ff.command      <= req_chan.command;
         in_data_ff.delta_x      <= req_chan.delta_x;
         in_data_ff.delta_y      <= req_chan.delta_y;
         in_data_ff.button_state <= req_chan.button_state;
      end
   end

   mec_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .item_valid  (in_valid_ff),
      .item_fire   (item_fire),
      .item        (in_data_ff),
      .item_has_rsp(item_has_rsp),
      .rsp_data    (rsp_data)
   );

   mec_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (item_fire && item_has_rsp),
      .load_data(rsp_data),
      .out_free (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== rtl/mec_checker.sv =====
// Port-level checker for the mouse event conditioner and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mec_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [mec_pkg::MASK_W-1:0]        rsp_event_mask,
   input logic signed [mec_pkg::DELTA_W-1:0] rsp_report_x,
   input logic signed [mec_pkg::DELTA_W-1:0] rsp_report_y
);
   import mec_pkg::*;

   // A stalled report holds
   `MEC_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_mask) &&
      $stable(rsp_report_x) && $stable(rsp_report_y))

   // No report right after reset
   `MEC_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid)

   // Without the move flag the report carries no motion
   `MEC_ASSERT(a_still_zero, clock, reset,
      rsp_valid && !rsp_event_mask[0] |-> rsp_report_x == '0 && rsp_report_y == '0)

   // A button never shows press and release together
   `MEC_ASSERT(a_btn_edge, clock, reset,
      rsp_valid |-> !(rsp_event_mask[1] && rsp_event_mask[2]) &&
      !(rsp_event_mask[3] && rsp_event_mask[4]) && !(rsp_event_mask[5] && rsp_event_mask[6]))

   // With the result register empty, input is never blocked
   `MEC_ASSERT(a_req_open, clock, reset, !rsp_valid |-> req_ready)

endmodule

bind mouse_event_conditioner_unit mec_checker u_mec_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_event_mask(rsp_chan.event_mask),
   .rsp_report_x  (rsp_chan.report_x),
   .rsp_report_y  (rsp_chan.report_y)
);
